/* design/lobm_pkg.sv */
package lobm_pkg;

    // fixed field widths of the item and result formats
    localparam int ID_W    = 10;
    localparam int PRICE_W = 10;
    localparam int VOL_W   = 32;
    localparam int TOT_W   = 42;
    localparam int SKIP_W  = 42;
    localparam int SUM_W   = TOT_W + 1;

    localparam logic [TOT_W-1:0] LEVEL_MAX = '1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_NO_VOLUME = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_QUERY,
        K_REJECT,
        K_CANCEL,
        K_PLACE
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                side;
        logic [ID_W-1:0]     id;
        logic [PRICE_W-1:0]  price;
        logic [VOL_W-1:0]    vol;
        logic [SKIP_W-1:0]   skip;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [PRICE_W-1:0]  top_price;
        logic [VOL_W-1:0]    rested;
    } t_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_QRD,
        S_QCK,
        S_ORD,
        S_OCK,
        S_C1,
        S_C2,
        S_CPOST,
        S_SCENT,
        S_SCRD,
        S_SCCK,
        S_MBEST,
        S_MRDH,
        S_MHEAD,
        S_MFILL,
        S_R1,
        S_R2,
        S_R3,
        S_RESP
    } t_bstate;

endpackage

/* design/lobm_if.sv */
interface lobm_req_if import lobm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ID_W-1:0]     order_ref;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [VOL_W-1:0]    volume;
    logic [SKIP_W-1:0]   skip_vol;

    modport source (output valid, operation, order_ref, side, price, volume, skip_vol,
                    input ready);
    modport sink   (input valid, operation, order_ref, side, price, volume, skip_vol,
                    output ready);
endinterface

interface lobm_rsp_if import lobm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [PRICE_W-1:0]  top_price;
    logic [VOL_W-1:0]    rested_volume;

    modport source (output valid, status, top_price, rested_volume, input ready);
    modport sink   (input valid, status, top_price, rested_volume, output ready);
endinterface

/* design/lobm_ram.sv */
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lobm_front.sv */
module lobm_front import lobm_pkg::*; #(
    parameter int ORDER_SLOTS  = 1024,
    parameter int PRICE_LEVELS = 1024
) (
    lobm_req_if.sink i_req,
    input  logic     i_full,
    input  logic     i_clearing,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic id_bad;
    logic price_bad;

    assign id_bad    = int'(i_req.order_ref) >= ORDER_SLOTS;
    assign price_bad = int'(i_req.price) >= PRICE_LEVELS;

    assign i_req.ready = !i_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.side  = i_req.side;
        o_cmd.id    = i_req.order_ref;
        o_cmd.price = i_req.price;
        o_cmd.vol   = i_req.volume;
        o_cmd.skip  = i_req.skip_vol;
        if (i_req.operation) begin
            o_cmd.kind = K_QUERY;
        end else if (id_bad) begin
            o_cmd.kind = K_REJECT;
        end else if (i_req.volume == '0) begin
            o_cmd.kind = K_CANCEL;
        end else if (price_bad) begin
            o_cmd.kind = K_REJECT;
        end else begin
            o_cmd.kind = K_PLACE;
        end
    end

endmodule

/* design/lobm_queue.sv */
module lobm_queue import lobm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd               r_mem [QDEPTH];
    logic [QPW-1:0]     r_wp;
    logic [QPW-1:0]     r_rp;
    logic [QPW:0]       r_cnt;

    assign o_full  = r_cnt == (QPW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPW+1)'(i_push) - (QPW+1)'(i_pop);
        end
    end

endmodule

/* design/lobm_back.sv */
module lobm_back import lobm_pkg::*; #(
    parameter int ORDER_SLOTS  = 1024,
    parameter int PRICE_LEVELS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_clearing,
    output logic o_rsp_valid,
    output t_rsp o_rsp,
    input  logic i_rsp_ready
);

    localparam int IW    = $clog2(ORDER_SLOTS);
    localparam int LW    = $clog2(ORDER_SLOTS + 1);
    localparam int PW    = $clog2(PRICE_LEVELS);
    localparam int TW    = $clog2(PRICE_LEVELS + 1);
    localparam int NLEV  = 2 * PRICE_LEVELS;
    localparam int LAW   = $clog2(NLEV);
    localparam int CLR_N = (ORDER_SLOTS > NLEV) ? ORDER_SLOTS : NLEV;
    localparam int CW    = $clog2(CLR_N);
    localparam int INF_W = PW + 2;

    localparam logic [LW-1:0] NULL_ORD  = LW'(ORDER_SLOTS);
    localparam logic [TW-1:0] NULL_TICK = TW'(PRICE_LEVELS);
    localparam logic [TW-1:0] TOP_TICK  = TW'(PRICE_LEVELS - 1);

    function automatic logic [LAW-1:0] lvl_addr(input logic s, input logic [TW-1:0] t);
        return s ? (LAW'(PRICE_LEVELS) + LAW'(t)) : LAW'(t);
    endfunction

    // memory ports
    logic              inf_we, rem_we, nxt_we, prv_we, tot_we, hd_we, tl_we;
    logic [IW-1:0]     inf_wa, rem_wa, nxt_wa, prv_wa;
    logic [IW-1:0]     inf_ra, rem_ra, nxt_ra, prv_ra;
    logic [LAW-1:0]    tot_wa, hd_wa, tl_wa, tot_ra, hd_ra, tl_ra;
    logic [INF_W-1:0]  inf_wd, inf_rd;
    logic [VOL_W-1:0]  rem_wd, rem_rd;
    logic [LW-1:0]     nxt_wd, nxt_rd, prv_wd, prv_rd, hd_wd, hd_rd, tl_wd, tl_rd;
    logic [TOT_W-1:0]  tot_wd, tot_rd;

    // state
    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [VOL_W-1:0]  r_vol, n_vol;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [TW-1:0]     r_t, n_t;
    logic [TW-1:0]     r_ask, n_ask;
    logic [TW-1:0]     r_bid, n_bid;
    logic [LAW-1:0]    r_lvl, n_lvl;
    logic [LW-1:0]     r_h, n_h;
    logic [LW-1:0]     r_tl, n_tl;
    logic [TOT_W-1:0]  r_tot, n_tot;
    logic              r_oside, n_oside;
    logic [PW-1:0]     r_oprice, n_oprice;
    logic [VOL_W-1:0]  r_orem, n_orem;
    logic              r_sside, n_sside;
    logic              r_match, n_match;
    logic [CW-1:0]     r_clr, n_clr;
    t_rsp              r_res, n_res;
    logic              r_rvalid, n_rvalid;
    t_rsp              r_rsp, n_rsp;

    // scratch
    logic [SUM_W-1:0]  q_sum;
    logic [TOT_W-1:0]  eff;
    logic [TOT_W-1:0]  ntot;
    logic [VOL_W-1:0]  nvol;
    logic [TW-1:0]     b_tick;
    logic              same_lvl;
    t_bstate           scan_ret;

    lobm_ram #(.WIDTH(INF_W), .DEPTH(ORDER_SLOTS)) u_inf (
        .i_clk(i_clk), .i_we(inf_we), .i_waddr(inf_wa), .i_wdata(inf_wd),
        .i_raddr(inf_ra), .o_rdata(inf_rd));
    lobm_ram #(.WIDTH(VOL_W), .DEPTH(ORDER_SLOTS)) u_rem (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_wa), .i_wdata(rem_wd),
        .i_raddr(rem_ra), .o_rdata(rem_rd));
    lobm_ram #(.WIDTH(LW), .DEPTH(ORDER_SLOTS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd));
    lobm_ram #(.WIDTH(LW), .DEPTH(ORDER_SLOTS)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_rd));
    lobm_ram #(.WIDTH(TOT_W), .DEPTH(NLEV)) u_tot (
        .i_clk(i_clk), .i_we(tot_we), .i_waddr(tot_wa), .i_wdata(tot_wd),
        .i_raddr(tot_ra), .o_rdata(tot_rd));
    lobm_ram #(.WIDTH(LW), .DEPTH(NLEV)) u_hd (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd));
    lobm_ram #(.WIDTH(LW), .DEPTH(NLEV)) u_tl (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_rd));

    assign o_clearing  = r_state == S_CLEAR;
    assign o_rsp_valid = r_rvalid;
    assign o_rsp       = r_rsp;
    assign scan_ret    = r_match ? S_MBEST : S_CPOST;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_vol    = r_vol;
        n_sum    = r_sum;
        n_t      = r_t;
        n_ask    = r_ask;
        n_bid    = r_bid;
        n_lvl    = r_lvl;
        n_h      = r_h;
        n_tl     = r_tl;
        n_tot    = r_tot;
        n_oside  = r_oside;
        n_oprice = r_oprice;
        n_orem   = r_orem;
        n_sside  = r_sside;
        n_match  = r_match;
        n_clr    = r_clr;
        n_res    = r_res;
        n_rvalid = r_rvalid;
        n_rsp    = r_rsp;
        o_pop    = 1'b0;

        inf_we = 1'b0; inf_wa = '0; inf_wd = '0; inf_ra = '0;
        rem_we = 1'b0; rem_wa = '0; rem_wd = '0; rem_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = '0;
        tot_we = 1'b0; tot_wa = '0; tot_wd = '0; tot_ra = '0;
        hd_we  = 1'b0; hd_wa  = '0; hd_wd  = '0; hd_ra  = '0;
        tl_we  = 1'b0; tl_wa  = '0; tl_wd  = '0; tl_ra  = '0;

        q_sum    = r_sum + SUM_W'(tot_rd);
        same_lvl = inf_rd[PW+1] && (inf_rd[PW] == r_cmd.side)
                   && (int'(inf_rd[PW-1:0]) == int'(r_cmd.price));
        eff      = tot_rd - (same_lvl ? TOT_W'(rem_rd) : '0);
        ntot     = '0;
        nvol     = '0;
        b_tick   = r_cmd.side ? r_bid : r_ask;

        if (r_rvalid && i_rsp_ready) begin
            n_rvalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                inf_we = int'(r_clr) < ORDER_SLOTS;
                inf_wa = IW'(r_clr);
                tot_we = int'(r_clr) < NLEV;
                tot_wa = LAW'(r_clr);
                hd_we  = tot_we;
                hd_wa  = LAW'(r_clr);
                hd_wd  = NULL_ORD;
                tl_we  = tot_we;
                tl_wa  = LAW'(r_clr);
                tl_wd  = NULL_ORD;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_vol   = i_cmd.vol;
                    n_match = 1'b0;
                    n_res   = '0;
                    case (i_cmd.kind)
                        K_QUERY: begin
                            n_sum   = '0;
                            n_t     = i_cmd.side ? '0 : TOP_TICK;
                            n_state = S_QRD;
                        end
                        K_REJECT: begin
                            n_res.status = ST_RANGE;
                            n_state      = S_RESP;
                        end
                        default: n_state = S_ORD;
                    endcase
                end
            end
            S_QRD: begin
                tot_ra  = lvl_addr(r_cmd.side, r_t);
                n_state = S_QCK;
            end
            S_QCK: begin
                n_sum = q_sum;
                if (q_sum > SUM_W'(r_cmd.skip)) begin
                    n_res.top_price = PRICE_W'(r_t);
                    n_state         = S_RESP;
                end else if (r_cmd.side ? (r_t == TOP_TICK) : (r_t == '0)) begin
                    n_res.status = ST_NO_VOLUME;
                    n_state      = S_RESP;
                end else begin
                    n_t     = r_cmd.side ? (r_t + 1'b1) : (r_t - 1'b1);
                    n_state = S_QRD;
                end
            end
            S_ORD: begin
                inf_ra  = IW'(r_cmd.id);
                rem_ra  = IW'(r_cmd.id);
                tot_ra  = lvl_addr(r_cmd.side, TW'(r_cmd.price));
                n_state = S_OCK;
            end
            S_OCK: begin
                n_oside  = inf_rd[PW];
                n_oprice = inf_rd[PW-1:0];
                n_orem   = rem_rd;
                if (r_cmd.kind == K_CANCEL) begin
                    if (!inf_rd[PW+1]) begin
                        n_res.status = ST_UNKNOWN;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_C1;
                    end
                end else if (SUM_W'(eff) + SUM_W'(r_cmd.vol) > SUM_W'(LEVEL_MAX)) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_RESP;
                end else if (inf_rd[PW+1]) begin
                    n_state = S_C1;
                end else begin
                    n_match = 1'b1;
                    n_state = S_MBEST;
                end
            end
            S_C1: begin
                prv_ra  = IW'(r_cmd.id);
                nxt_ra  = IW'(r_cmd.id);
                tot_ra  = lvl_addr(r_oside, TW'(r_oprice));
                n_state = S_C2;
            end
            S_C2: begin
                ntot   = tot_rd - TOT_W'(r_orem);
                tot_we = 1'b1;
                tot_wa = lvl_addr(r_oside, TW'(r_oprice));
                tot_wd = ntot;
                inf_we = 1'b1;
                inf_wa = IW'(r_cmd.id);
                if (prv_rd == NULL_ORD) begin
                    hd_we = 1'b1;
                    hd_wa = tot_wa;
                    hd_wd = nxt_rd;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = IW'(prv_rd);
                    nxt_wd = nxt_rd;
                end
                if (nxt_rd == NULL_ORD) begin
                    tl_we = 1'b1;
                    tl_wa = tot_wa;
                    tl_wd = prv_rd;
                end else begin
                    prv_we = 1'b1;
                    prv_wa = IW'(nxt_rd);
                    prv_wd = prv_rd;
                end
                if (ntot == '0 && TW'(r_oprice) == (r_oside ? r_ask : r_bid)) begin
                    n_sside = r_oside;
                    n_t     = TW'(r_oprice);
                    n_state = S_SCENT;
                end else begin
                    n_state = S_CPOST;
                end
            end
            S_CPOST: begin
                if (r_cmd.kind == K_CANCEL) begin
                    n_state = S_RESP;
                end else begin
                    n_match = 1'b1;
                    n_state = S_MBEST;
                end
            end
            S_SCENT: begin
                // step one tick away from the emptied best, towards worse prices
                if (r_sside) begin
                    if (r_t == TOP_TICK) begin
                        n_ask   = NULL_TICK;
                        n_state = scan_ret;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = S_SCRD;
                    end
                end else begin
                    if (r_t == '0) begin
                        n_bid   = NULL_TICK;
                        n_state = scan_ret;
                    end else begin
                        n_t     = r_t - 1'b1;
                        n_state = S_SCRD;
                    end
                end
            end
            S_SCRD: begin
                tot_ra  = lvl_addr(r_sside, r_t);
                n_state = S_SCCK;
            end
            S_SCCK: begin
                if (tot_rd != '0) begin
                    if (r_sside) begin
                        n_ask = r_t;
                    end else begin
                        n_bid = r_t;
                    end
                    n_state = scan_ret;
                end else begin
                    n_state = S_SCENT;
                end
            end
            S_MBEST: begin
                if (r_vol == '0) begin
                    n_state = S_RESP;
                end else if (b_tick == NULL_TICK
                             || (r_cmd.side ? (int'(b_tick) < int'(r_cmd.price))
                                            : (int'(b_tick) > int'(r_cmd.price)))) begin
                    n_state = S_R1;
                end else begin
                    n_lvl   = lvl_addr(!r_cmd.side, b_tick);
                    n_t     = b_tick;
                    n_sside = !r_cmd.side;
                    n_state = S_MRDH;
                end
            end
            S_MRDH: begin
                hd_ra   = r_lvl;
                tot_ra  = r_lvl;
                n_state = S_MHEAD;
            end
            S_MHEAD: begin
                n_h     = hd_rd;
                n_tot   = tot_rd;
                rem_ra  = IW'(hd_rd);
                nxt_ra  = IW'(hd_rd);
                n_state = S_MFILL;
            end
            S_MFILL: begin
                if (rem_rd <= r_vol) begin
                    // resting order filled completely and leaves its queue
                    nvol   = r_vol - rem_rd;
                    ntot   = r_tot - TOT_W'(rem_rd);
                    n_vol  = nvol;
                    n_tot  = ntot;
                    tot_we = 1'b1;
                    tot_wa = r_lvl;
                    tot_wd = ntot;
                    inf_we = 1'b1;
                    inf_wa = IW'(r_h);
                    hd_we  = 1'b1;
                    hd_wa  = r_lvl;
                    hd_wd  = nxt_rd;
                    if (nxt_rd == NULL_ORD) begin
                        tl_we = 1'b1;
                        tl_wa = r_lvl;
                        tl_wd = NULL_ORD;
                    end else begin
                        prv_we = 1'b1;
                        prv_wa = IW'(nxt_rd);
                        prv_wd = NULL_ORD;
                    end
                    if (ntot == '0) begin
                        n_state = S_SCENT;
                    end else if (nvol == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_h    = nxt_rd;
                        rem_ra = IW'(nxt_rd);
                        nxt_ra = IW'(nxt_rd);
                    end
                end else begin
                    // partial fill of the head order
                    rem_we  = 1'b1;
                    rem_wa  = IW'(r_h);
                    rem_wd  = rem_rd - r_vol;
                    tot_we  = 1'b1;
                    tot_wa  = r_lvl;
                    tot_wd  = r_tot - TOT_W'(r_vol);
                    n_vol   = '0;
                    n_state = S_RESP;
                end
            end
            S_R1: begin
                n_lvl   = lvl_addr(r_cmd.side, TW'(r_cmd.price));
                tl_ra   = n_lvl;
                tot_ra  = n_lvl;
                n_state = S_R2;
            end
            S_R2: begin
                n_tl    = tl_rd;
                n_tot   = tot_rd;
                inf_we  = 1'b1;
                inf_wa  = IW'(r_cmd.id);
                inf_wd  = {1'b1, r_cmd.side, PW'(r_cmd.price)};
                rem_we  = 1'b1;
                rem_wa  = IW'(r_cmd.id);
                rem_wd  = r_vol;
                prv_we  = 1'b1;
                prv_wa  = IW'(r_cmd.id);
                prv_wd  = tl_rd;
                nxt_we  = 1'b1;
                nxt_wa  = IW'(r_cmd.id);
                nxt_wd  = NULL_ORD;
                n_state = S_R3;
            end
            S_R3: begin
                if (r_tl == NULL_ORD) begin
                    hd_we = 1'b1;
                    hd_wa = r_lvl;
                    hd_wd = LW'(r_cmd.id);
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = IW'(r_tl);
                    nxt_wd = LW'(r_cmd.id);
                end
                tl_we  = 1'b1;
                tl_wa  = r_lvl;
                tl_wd  = LW'(r_cmd.id);
                tot_we = 1'b1;
                tot_wa = r_lvl;
                tot_wd = r_tot + TOT_W'(r_vol);
                if (r_cmd.side) begin
                    if (TW'(r_cmd.price) < r_ask) begin
                        n_ask = TW'(r_cmd.price);
                    end
                end else begin
                    if (r_bid == NULL_TICK || TW'(r_cmd.price) > r_bid) begin
                        n_bid = TW'(r_cmd.price);
                    end
                end
                n_res.rested = r_vol;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_rvalid || i_rsp_ready) begin
                    n_rvalid = 1'b1;
                    n_rsp    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ask    <= NULL_TICK;
            r_bid    <= NULL_TICK;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ask    <= n_ask;
            r_bid    <= n_bid;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_vol    <= n_vol;
        r_sum    <= n_sum;
        r_t      <= n_t;
        r_lvl    <= n_lvl;
        r_h      <= n_h;
        r_tl     <= n_tl;
        r_tot    <= n_tot;
        r_oside  <= n_oside;
        r_oprice <= n_oprice;
        r_orem   <= n_orem;
        r_sside  <= n_sside;
        r_match  <= n_match;
        r_res    <= n_res;
        r_rsp    <= n_rsp;
    end

endmodule

/* design/limit_order_book_matcher.sv */
// Limit order book with price-time priority. Each request transfer is either an order
// update (place, modify or cancel by order id) or a top-of-book query; each gives exactly
// one response transfer, in order. After reset the block runs a clearing pass of
// max(ORDER_SLOTS, 2*PRICE_LEVELS) addresses (2048 at the defaults) with i_req.ready low.
// A front stage classifies requests into a two-entry command queue, so up to two further
// requests are taken while the engine is busy and the response register waits.
// The engine walks the order and level memories; their reads are registered, so each read
// takes an address state and a data state. A cancel reads the order and unlinks it; a place
// unlinks the order first when it modifies a resting one, then matches against each crossing
// opposite level, filling resting orders from the head, and rests any remainder at the tail
// of its level. When the best level empties, the engine scans outward to the next non-empty
// tick. A query walks its side level by level from the extreme tick.
module limit_order_book_matcher import lobm_pkg::*; #(
    parameter int ORDER_SLOTS  = 1024,
    parameter int PRICE_LEVELS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lobm_req_if.sink   i_req,
    lobm_rsp_if.source o_rsp
);

    // front to queue
    logic q_push;
    t_cmd q_in;
    logic q_full;
    // queue to engine
    logic q_valid;
    t_cmd q_out;
    logic q_pop;
    // engine status
    logic clearing;
    logic rsp_valid;
    t_rsp rsp;

    lobm_front #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_front (
        .i_req      (i_req),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    lobm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    // engine: owns the order and level memories and the best-tick registers
    lobm_back #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_ready (o_rsp.ready)
    );

    assign o_rsp.valid         = rsp_valid;
    assign o_rsp.status        = rsp.status;
    assign o_rsp.top_price     = rsp.top_price;
    assign o_rsp.rested_volume = rsp.rested;

endmodule

/* design/lobm_checker.sv */
module lobm_checker import lobm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [1:0]         i_rsp_status,
    input logic [PRICE_W-1:0] i_rsp_top,
    input logic [VOL_W-1:0]   i_rsp_rested
);

    logic [7:0] r_outst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 8'(i_req_valid && i_req_ready)
                       - 8'(i_rsp_valid && i_rsp_ready);
        end
    end

    // no transfer is taken right after reset, when the clearing pass starts
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request taken during clearing pass");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outst != '0)
        else $error("response without pending request");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_top == '0 && i_rsp_rested == '0)
        else $error("error response carries data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_top)
            && $stable(i_rsp_rested))
        else $error("stalled response changed");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_top    (o_rsp.top_price),
    .i_rsp_rested (o_rsp.rested_volume)
);

/* bench/limit_order_book_matcher_test.sv */
module limit_order_book_matcher_test;
    import lobm_pkg::*;

    localparam int N_SLOTS   = 1024;
    localparam int N_TICKS   = 1024;
    localparam int NO_ORDER  = N_SLOTS;
    localparam int NO_TICK   = N_TICKS;
    localparam int N_RANDOM  = 900;
    localparam int MAX_IDLE  = 14;
    localparam int CYCLE_CAP = 40000000;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Holds a shadow copy of the book and the queue of responses it predicts.
    class book_scoreboard;
        bit          ord_live[N_SLOTS];
        bit          ord_side[N_SLOTS];
        int          ord_tick[N_SLOTS];
        logic [31:0] ord_left[N_SLOTS];
        int          ord_next[N_SLOTS];
        int          ord_prev[N_SLOTS];
        logic [63:0] lvl_sum[2*N_TICKS];
        int          lvl_first[2*N_TICKS];
        int          lvl_last[2*N_TICKS];
        int          best_ask;
        int          best_bid;
        t_rsp        awaited[$];
        int          errors;

        function new();
            for (int i = 0; i < N_SLOTS; i++) ord_live[i] = 0;
            for (int i = 0; i < 2*N_TICKS; i++) begin
                lvl_sum[i]   = 0;
                lvl_first[i] = NO_ORDER;
                lvl_last[i]  = NO_ORDER;
            end
            best_ask = NO_TICK;
            best_bid = NO_TICK;
            errors   = 0;
        endfunction

        function void find_best();
            best_ask = NO_TICK;
            best_bid = NO_TICK;
            for (int t = 0; t < N_TICKS; t++)
                if (lvl_sum[N_TICKS+t] != 0) begin
                    best_ask = t;
                    break;
                end
            for (int t = N_TICKS-1; t >= 0; t--)
                if (lvl_sum[t] != 0) begin
                    best_bid = t;
                    break;
                end
        endfunction

        function void unlink(int id);
            int lvl;
            int p;
            int n;
            lvl = ord_side[id]*N_TICKS + ord_tick[id];
            p = ord_prev[id];
            n = ord_next[id];
            if (p == NO_ORDER) lvl_first[lvl] = n; else ord_next[p] = n;
            if (n == NO_ORDER) lvl_last[lvl] = p; else ord_prev[n] = p;
            ord_live[id] = 0;
        endfunction

        function void drop_order(int id);
            lvl_sum[ord_side[id]*N_TICKS + ord_tick[id]] -= ord_left[id];
            unlink(id);
            find_best();
        endfunction

        // match against the opposite side while prices cross, then rest the rest
        function logic [31:0] match_and_rest(int id, bit s, int px, logic [31:0] v);
            int b;
            int lvl;
            int h;
            int t;
            while (v != 0) begin
                b = (s == SIDE_BUY) ? best_ask : best_bid;
                if (b == NO_TICK) break;
                if ((s == SIDE_BUY) ? (b > px) : (b < px)) break;
                lvl = (s ^ 1'b1)*N_TICKS + b;
                while (lvl_sum[lvl] != 0 && v != 0) begin
                    h = lvl_first[lvl];
                    if (h == NO_ORDER) begin
                        lvl_sum[lvl] = 0;
                        break;
                    end
                    if (ord_left[h] <= v) begin
                        v -= ord_left[h];
                        lvl_sum[lvl] -= ord_left[h];
                        unlink(h);
                    end else begin
                        ord_left[h] -= v;
                        lvl_sum[lvl] -= v;
                        v = 0;
                    end
                end
                if (lvl_sum[lvl] == 0) find_best();
            end
            if (v != 0) begin
                lvl = s*N_TICKS + px;
                ord_live[id] = 1;
                ord_side[id] = s;
                ord_tick[id] = px;
                ord_left[id] = v;
                t = lvl_last[lvl];
                ord_prev[id] = t;
                ord_next[id] = NO_ORDER;
                if (t == NO_ORDER) lvl_first[lvl] = id; else ord_next[t] = id;
                lvl_last[lvl] = id;
                lvl_sum[lvl] += v;
                find_best();
            end
            return v;
        endfunction

        function void note(logic op, logic [9:0] id, logic s, logic [9:0] px,
                           logic [31:0] v, logic [41:0] skip);
            t_rsp        r;
            logic [63:0] acc;
            logic [63:0] eff;
            int          tick;
            bit          hit;
            r.status    = ST_OK;
            r.top_price = '0;
            r.rested    = '0;
            if (op == OP_QUERY) begin
                acc = 0;
                hit = 0;
                for (int t = 0; t < N_TICKS && !hit; t++) begin
                    tick = s ? t : N_TICKS-1-t;
                    acc += lvl_sum[s*N_TICKS + tick];
                    if (acc > skip) begin
                        hit = 1;
                        r.top_price = 10'(tick);
                    end
                end
                if (!hit) r.status = ST_NO_VOLUME;
            end else if (v == 0) begin
                if (!ord_live[id]) r.status = ST_UNKNOWN;
                else drop_order(id);
            end else begin
                eff = lvl_sum[s*N_TICKS + px];
                if (ord_live[id] && ord_side[id] == s && ord_tick[id] == px)
                    eff -= ord_left[id];
                if (eff + v > 64'(LEVEL_MAX)) r.status = ST_RANGE;
                else begin
                    if (ord_live[id]) drop_order(id);
                    r.rested = match_and_rest(id, s, px, v);
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check(logic [1:0] st, logic [9:0] top, logic [31:0] rested);
            t_rsp e;
            if (awaited.size() == 0) begin
                $display("%0t: response with nothing awaited: status %0d top %0d rested %0d",
                         $time, st, top, rested);
                errors++;
                return;
            end
            e = awaited[0];
            awaited.delete(0);
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (top !== e.top_price) begin
                $display("%0t: top_price expected %0d actual %0d", $time, e.top_price, top);
                errors++;
            end
            if (rested !== e.rested) begin
                $display("%0t: rested_volume expected %0d actual %0d",
                         $time, e.rested, rested);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    bit   send_idle;
    bit   recv_idle;

    lobm_req_if req_bus();
    lobm_rsp_if rsp_bus();

    limit_order_book_matcher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    book_scoreboard book = new();

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // hang guard
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("limit_order_book_matcher_test: FAIL");
            $finish;
        end
    end

    // drive one request, transfer completes at the edge where ready is seen high
    task automatic send_item(logic op, logic [9:0] id, logic s, logic [9:0] px,
                             logic [31:0] v, logic [41:0] skip);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.order_ref <= id;
        req_bus.side      <= s;
        req_bus.price     <= px;
        req_bus.volume    <= v;
        req_bus.skip_vol  <= skip;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        book.note(op, id, s, px, v, skip);
    endtask

    // random update or query; ids from a small pool so modifies and cancels hit
    task automatic send_random();
        int          pick;
        logic [9:0]  id;
        logic        s;
        logic [9:0]  px;
        logic [31:0] v;
        logic [41:0] skip;
        pick = $urandom_range(0, 99);
        id   = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
        s    = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 19) == 0) px = 10'($urandom);
        else px = s ? 10'($urandom_range(495, 530)) : 10'($urandom_range(485, 520));
        if ($urandom_range(0, 14) == 0) v = $urandom;
        else v = $urandom_range(1, 1000);
        if ($urandom_range(0, 3) == 0) skip = 42'({$urandom, $urandom});
        else skip = 42'($urandom_range(0, 4000));
        if (pick < 8) send_item(OP_QUERY, 10'($urandom), s, 10'($urandom), $urandom, skip);
        else if (pick < 22) send_item(OP_UPDATE, id, s, 10'($urandom), 32'd0, skip);
        else send_item(OP_UPDATE, id, s, px, v, skip);
    endtask

    // response side
    initial begin
        forever begin
            int stall;
            stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            book.check(rsp_bus.status, rsp_bus.top_price, rsp_bus.rested_volume);
        end
    end

    initial begin
        send_idle = 1'b1;
        recv_idle = 1'b1;
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= OP_UPDATE;
        req_bus.order_ref <= '0;
        req_bus.side      <= SIDE_BUY;
        req_bus.price     <= '0;
        req_bus.volume    <= '0;
        req_bus.skip_vol  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, matching, modify, cancel, queries
        send_item(OP_QUERY,  10'd0,    SIDE_BUY,  10'd0,    32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd5,    SIDE_BUY,  10'd7,    32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd0,    SIDE_BUY,  10'd1023, 32'hFFFF_FFFF, 42'd0);
        send_item(OP_QUERY,  10'd1023, SIDE_BUY,  10'd1023, 32'hFFFF_FFFF, 42'd0);
        send_item(OP_QUERY,  10'd0,    SIDE_BUY,  10'd0,    32'd0, 42'h3FF_FFFF_FFFF);
        send_item(OP_QUERY,  10'd0,    SIDE_SELL, 10'd0,    32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd1,    SIDE_SELL, 10'd0,    32'd1, 42'h3FF_FFFF_FFFF);
        send_item(OP_UPDATE, 10'd1023, SIDE_SELL, 10'd1023, 32'd10, 42'd0);
        send_item(OP_UPDATE, 10'd2,    SIDE_BUY,  10'd0,    32'd7, 42'd0);
        send_item(OP_UPDATE, 10'd3,    SIDE_BUY,  10'd0,    32'd9, 42'd0);
        send_item(OP_UPDATE, 10'd2,    SIDE_BUY,  10'd0,    32'd5, 42'd0);
        send_item(OP_UPDATE, 10'd2,    SIDE_BUY,  10'd3,    32'd6, 42'd0);
        send_item(OP_UPDATE, 10'd0,    SIDE_BUY,  10'd512,  32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd4,    SIDE_SELL, 10'd0,    32'd12, 42'd0);
        send_item(OP_QUERY,  10'd0,    SIDE_BUY,  10'd0,    32'd0, 42'd2);
        send_item(OP_UPDATE, 10'd6,    SIDE_BUY,  10'd1023, 32'd30, 42'd0);
        send_item(OP_QUERY,  10'd0,    SIDE_SELL, 10'd0,    32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd7,    SIDE_SELL, 10'd1000, 32'hFFFF_FFFF, 42'd0);
        send_item(OP_QUERY,  10'd0,    SIDE_SELL, 10'd0,    32'd0, 42'h0FF_FFFF_FFFF);
        send_item(OP_UPDATE, 10'd1023, SIDE_SELL, 10'd0,    32'd0, 42'd0);
        send_item(OP_UPDATE, 10'd1023, SIDE_SELL, 10'd0,    32'd0, 42'd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) begin
                send_idle = $urandom_range(0, 2) != 0;
                recv_idle = $urandom_range(0, 2) != 0;
            end
            send_random();
        end
        req_bus.valid <= 1'b0;

        while (book.awaited.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (book.errors == 0 && book.awaited.size() == 0) begin
            $display("limit_order_book_matcher_test: PASS");
        end else begin
            $display("limit_order_book_matcher_test: FAIL");
        end
        $finish;
    end

endmodule
